[src/lbs_pkg.sv]
// Shared types and constants of the LED blink sequencer.
package lbs_pkg;

  localparam int LED_COUNT_DEF  = 3;
  localparam int TIME_WIDTH_DEF = 16;

  localparam int FUNC_W  = 2;
  localparam int LED_W   = 2;
  localparam int REPS_W  = 8;
  localparam int TICKS_W = 16;
  localparam int OUT_W   = 3;
  localparam int REPL_W  = 9;

  // Item kinds. The fourth code carries no meaning and leaves the state alone.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  // Command broadcast from the top level to every LED cell.
  typedef struct packed {
    logic              step;
    func_t             func;
    logic              sel;
    logic              rest;
    logic [REPS_W-1:0] reps;
  } cmd_t;

endpackage

[src/lbs_led_cell.sv]
// State and update logic of one LED of the blink sequencer.
module lbs_led_cell #(
  parameter int TIME_WIDTH = lbs_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lbs_pkg::cmd_t              cmd,
  input  logic [lbs_pkg::TICKS_W-1:0] on_ticks,
  input  logic [lbs_pkg::TICKS_W-1:0] off_ticks,
  output logic                       level_next,
  output logic                       running_next
);

  localparam int TW_IN = (TIME_WIDTH < lbs_pkg::TICKS_W) ? TIME_WIDTH : lbs_pkg::TICKS_W;
  localparam logic signed [lbs_pkg::REPL_W-1:0] REP_MIN = {1'b1, {(lbs_pkg::REPL_W-1){1'b0}}};
  localparam logic signed [lbs_pkg::REPL_W-1:0] REP_ONE = {{(lbs_pkg::REPL_W-1){1'b0}}, 1'b1};
  localparam logic [TIME_WIDTH-1:0] TIME_ONE = {{(TIME_WIDTH-1){1'b0}}, 1'b1};

  logic                             level;
  logic                             resting;
  logic signed [lbs_pkg::REPL_W-1:0] repeats_left;
  logic [TIME_WIDTH-1:0]            on_duration;
  logic [TIME_WIDTH-1:0]            off_duration;
  logic [TIME_WIDTH-1:0]            countdown;
  logic                             running;

  logic                             resting_next;
  logic signed [lbs_pkg::REPL_W-1:0] repeats_left_next;
  logic [TIME_WIDTH-1:0]            on_duration_next;
  logic [TIME_WIDTH-1:0]            off_duration_next;
  logic [TIME_WIDTH-1:0]            countdown_next;

  logic [TIME_WIDTH-1:0]            on_t;
  logic [TIME_WIDTH-1:0]            off_t;
  logic [TIME_WIDTH-1:0]            cd_dec;
  logic [TIME_WIDTH-1:0]            reload;
  logic [TIME_WIDTH-1:0]            start_load;

  assign on_t  = TIME_WIDTH'(on_ticks[TW_IN-1:0]);
  assign off_t = TIME_WIDTH'(off_ticks[TW_IN-1:0]);

  always_comb begin
    cd_dec = (countdown != '0) ? countdown - TIME_ONE : countdown;
    // Reload after a toggle picks the time that matches the new level.
    reload = level ? off_duration : on_duration;
    if (reload == '0) begin
      reload = TIME_ONE;
    end
    start_load = cmd.rest ? off_t : on_t;
    if (start_load == '0) begin
      start_load = TIME_ONE;
    end
  end

  always_comb begin
    level_next        = level;
    resting_next      = resting;
    repeats_left_next = repeats_left;
    on_duration_next  = on_duration;
    off_duration_next = off_duration;
    countdown_next    = countdown;
    running_next      = running;
    if (cmd.step) begin
      case (cmd.func)
        lbs_pkg::FUNC_TICK: begin
          if (running) begin
            countdown_next = cd_dec;
            if (cd_dec == '0) begin
              if ((level == resting) && (repeats_left <= REP_ONE)) begin
                // Last repeat used up: stop and keep the current level.
                repeats_left_next = repeats_left - REP_ONE;
                running_next      = 1'b0;
                countdown_next    = '0;
              end else begin
                if (level == resting) begin
                  repeats_left_next = (repeats_left == REP_MIN) ? REP_MIN
                                                                : repeats_left - REP_ONE;
                end
                level_next     = ~level;
                countdown_next = reload;
              end
            end
          end
        end
        lbs_pkg::FUNC_START: begin
          if (cmd.sel) begin
            repeats_left_next = $signed({1'b0, cmd.reps});
            if (!running) begin
              resting_next      = cmd.rest;
              level_next        = ~cmd.rest;
              on_duration_next  = on_t;
              off_duration_next = off_t;
              countdown_next    = start_load;
              running_next      = 1'b1;
            end
          end
        end
        lbs_pkg::FUNC_STOP: begin
          if (cmd.sel && running) begin
            resting_next      = cmd.rest;
            level_next        = cmd.rest;
            repeats_left_next = '0;
            countdown_next    = '0;
            running_next      = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= 1'b0;
      resting      <= 1'b0;
      repeats_left <= '0;
      on_duration  <= '0;
      off_duration <= '0;
      countdown    <= '0;
      running      <= 1'b0;
    end else begin
      level        <= level_next;
      resting      <= resting_next;
      repeats_left <= repeats_left_next;
      on_duration  <= on_duration_next;
      off_duration <= off_duration_next;
      countdown    <= countdown_next;
      running      <= running_next;
    end
  end

endmodule

[src/led_blink_sequencer_unit.sv]
// Top level of the LED blink sequencer: input register, LED cells and result register.
//
// The sequencer drives LED_COUNT indicator LEDs. Every input beat is a tick, a start or a
// stop. A tick counts down the timers of all running LEDs at once; when a timer runs out,
// an LED at its resting level spends one repeat and stops when none remain, and otherwise
// it toggles and reloads its timer with the on or off time (a time of zero counts as one
// tick). A start sets the repeat count and, on an idle LED, drives the level opposite to
// the resting level and latches both times; a start on a running LED changes only its
// repeat count. A stop on a running LED cancels it and restores the resting level. Every
// input beat yields exactly one output beat with the LED levels and the running mask after
// that beat took effect; only LEDs 0 to 2 appear there. The block takes one beat per clock
// cycle while the result side is not stalled; a beat passes through the input register and
// then the result register, with all LED updates done in between.
module led_blink_sequencer_unit #(
  parameter int LED_COUNT  = lbs_pkg::LED_COUNT_DEF,
  parameter int TIME_WIDTH = lbs_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lbs_pkg::FUNC_W-1:0]  func,
  input  logic [lbs_pkg::LED_W-1:0]   led,
  input  logic [lbs_pkg::REPS_W-1:0]  repeat_count,
  input  logic [lbs_pkg::TICKS_W-1:0] on_ticks,
  input  logic [lbs_pkg::TICKS_W-1:0] off_ticks,
  input  logic                        rest_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lbs_pkg::OUT_W-1:0]   led_levels,
  output logic [lbs_pkg::OUT_W-1:0]   running_mask
);

  // Input register.
  logic                        in_full;
  logic [lbs_pkg::FUNC_W-1:0]  func_q;
  logic [lbs_pkg::LED_W-1:0]   led_q;
  logic [lbs_pkg::REPS_W-1:0]  reps_q;
  logic [lbs_pkg::TICKS_W-1:0] on_q;
  logic [lbs_pkg::TICKS_W-1:0] off_q;
  logic                        rest_q;

  logic                        advance;
  logic [LED_COUNT-1:0]        level_next;
  logic [LED_COUNT-1:0]        running_next;
  logic [lbs_pkg::OUT_W-1:0]   levels_next;
  logic [lbs_pkg::OUT_W-1:0]   mask_next;

  // The held beat moves on whenever the result register is empty or being emptied, so the
  // input side then takes the next beat; only a held beat behind a stalled result stalls it.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q <= func;
      led_q  <= led;
      reps_q <= repeat_count;
      on_q   <= on_ticks;
      off_q  <= off_ticks;
      rest_q <= rest_level;
    end
  end

  // One cell per LED; a start or stop reaches only the cell whose index matches, so an
  // index at or beyond LED_COUNT is ignored.
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
    lbs_pkg::cmd_t cmd;

    always_comb begin
      cmd.step = advance;
      cmd.func = lbs_pkg::func_t'(func_q);
      cmd.sel  = (32'(led_q) == i);
      cmd.rest = rest_q;
      cmd.reps = reps_q;
    end

    lbs_led_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .on_ticks    (on_q),
      .off_ticks   (off_q),
      .level_next  (level_next[i]),
      .running_next(running_next[i])
    );
  end

  // Only the first three LEDs are reported; missing LEDs read as zero.
  for (genvar b = 0; b < lbs_pkg::OUT_W; b++) begin : g_out
    if (b < LED_COUNT) begin : g_used
      assign levels_next[b] = level_next[b];
      assign mask_next[b]   = running_next[b];
    end else begin : g_pad
      assign levels_next[b] = 1'b0;
      assign mask_next[b]   = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_levels   <= levels_next;
      running_mask <= mask_next;
    end
  end

endmodule

[src/lbs_checker.sv]
// Port-level checker of the LED blink sequencer and its bind to the top level.
module lbs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lbs_pkg::OUT_W-1:0]   led_levels,
  input logic [lbs_pkg::OUT_W-1:0]   running_mask
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(led_levels) && $stable(running_mask)))
    else $error("result beat changed while stalled");

  // The input side only stalls behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // Every accepted input beat is followed by a valid result once it has passed the input and result registers.
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("accepted beat produced no result");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind led_blink_sequencer_unit lbs_checker u_lbs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .led_levels  (led_levels),
  .running_mask(running_mask)
);
